// ===== rtl/tcsc_pkg.sv =====
// Shared constants, types and codes of the touch calibration sample collector.
`timescale 1ns / 1ps

package tcsc_pkg;

   // Run geometry
   localparam int POINTS      = 9;
   localparam int SAMPLES     = 3;
   localparam int SAMPLE_BITS = 12;

   // Field widths
   localparam int RAW_W    = 12;
   localparam int TIME_W   = 32;
   localparam int DEB_W    = 16;
   localparam int DEV_W    = 12;
   localparam int OUT_PT_W = 4;
   localparam int OUT_PS_W = 2;

   // Derived widths
   localparam int POINT_W = $clog2(POINTS + 1);
   localparam int CNT_W   = $clog2(SAMPLES + 1);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(SAMPLES);
   localparam int CMP_W   = (SUM_W > DEV_W) ? SUM_W : DEV_W;
   localparam int STEP_W  = $clog2(SUM_W + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEV  = 1'd1;
   localparam logic [DEB_W-1:0]     DEBOUNCE_RST = 16'd100;
   localparam logic [DEV_W-1:0]     MAX_DEV_RST  = 12'd200;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_START,
      KIND_TOUCH,
      KIND_RELEASE
   } item_kind_type;

   typedef struct packed {
      item_kind_type          kind;
      logic [SAMPLE_BITS-1:0] sample_x;
      logic [SAMPLE_BITS-1:0] sample_y;
      logic [TIME_W-1:0]      now_ms;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } q_wr_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_rd_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [DEB_W-1:0] debounce_ms;
      logic [DEV_W-1:0] max_deviation;
   } cfg_type;

endpackage

// ===== rtl/tcsc_req_if.sv =====
// Request channel: touch samples and start commands.
`timescale 1ns / 1ps

interface tcsc_req_if;
   import tcsc_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [RAW_W-1:0]  raw_x;
   logic [RAW_W-1:0]  raw_y;
   logic              touch_valid;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, action, raw_x, raw_y, touch_valid, now_ms, input ready);
   modport sink   (input valid, action, raw_x, raw_y, touch_valid, now_ms, output ready);
endinterface

// ===== rtl/tcsc_rsp_if.sv =====
// Response channel: per-beat status of the collector.
`timescale 1ns / 1ps

interface tcsc_rsp_if;
   import tcsc_pkg::*;

   logic                valid;
   logic                ready;
   logic                complete;
   logic                accepted;
   logic                rejected_far;
   logic                active;
   logic [OUT_PT_W-1:0] point_index;
   logic [OUT_PS_W-1:0] point_samples;

   modport source (output valid, complete, accepted, rejected_far, active, point_index,
                   point_samples, input ready);
   modport sink   (input valid, complete, accepted, rejected_far, active, point_index,
                   point_samples, output ready);
endinterface

// ===== rtl/tcsc_front.sv =====
// Front stage: takes request beats, classifies them and pushes them into the queue.
`timescale 1ns / 1ps

module tcsc_front (
   input  logic              clock,
   input  logic              reset,
   tcsc_req_if.sink          req,
   input  logic              q_full,
   output tcsc_pkg::q_wr_type q_wr
);
   import tcsc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     beat;
   logic     push;

   assign push      = valid_ff && !q_full;
   assign req.ready = !valid_ff || !q_full;
   assign beat      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (beat) begin
         valid_in = 1'b1;
         if (req.action) begin
            item_in.kind = KIND_START;
         end else if (req.touch_valid) begin
            item_in.kind = KIND_TOUCH;
         end else begin
            item_in.kind = KIND_RELEASE;
         end
         item_in.sample_x = req.raw_x[SAMPLE_BITS-1:0];
         item_in.sample_y = req.raw_y[SAMPLE_BITS-1:0];
         item_in.now_ms   = req.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign q_wr.push = push;
   assign q_wr.item = item_ff;

endmodule

// ===== rtl/tcsc_fifo.sv =====
// Short first-word-fall-through queue between front and back.
`timescale 1ns / 1ps

module tcsc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  tcsc_pkg::q_wr_type q_wr,
   output logic               q_full,
   input  logic               q_pop,
   output tcsc_pkg::q_rd_type q_rd
);
   import tcsc_pkg::*;

   item_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = q_wr.push && !q_full;
   assign do_pop  = q_pop && (count_ff != '0);

   assign q_rd.valid = (count_ff != '0);
   assign q_rd.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_wr.item;
      end
   end

endmodule

// ===== rtl/tcsc_div.sv =====
// Serial restoring divider, one quotient bit per cycle, for the running average.
`timescale 1ns / 1ps

module tcsc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tcsc_pkg::div_req_type div_req,
   output tcsc_pkg::div_rsp_type div_rsp
);
   import tcsc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W:0]    shifted;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      steps_in   = steps_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         steps_in   = STEP_W'(SUM_W);
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = CNT_W'(shifted - {1'b0, divisor_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      steps_ff   <= steps_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/tcsc_back.sv =====
// Back stage: run state, debounce and deviation checks, per-point sums, result register.
`timescale 1ns / 1ps

module tcsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tcsc_pkg::cfg_type     cfg,
   input  tcsc_pkg::q_rd_type    q_rd,
   output logic                  q_pop,
   output tcsc_pkg::div_req_type div_x_req,
   output tcsc_pkg::div_req_type div_y_req,
   input  tcsc_pkg::div_rsp_type div_x_rsp,
   input  tcsc_pkg::div_rsp_type div_y_rsp,
   tcsc_rsp_if.source            rsp
);
   import tcsc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_DIV
   } state_type;

   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic               running_ff, running_in;
   logic [POINT_W-1:0] point_ff, point_in;
   logic               prev_valid_ff, prev_valid_in;
   logic [TIME_W-1:0]  last_time_ff, last_time_in;
   logic [SUM_W-1:0]   sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]   sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_complete_ff, out_complete_in;
   logic                out_accepted_ff, out_accepted_in;
   logic                out_far_ff, out_far_in;
   logic                out_active_ff, out_active_in;
   logic [OUT_PT_W-1:0] out_point_ff, out_point_in;
   logic [OUT_PS_W-1:0] out_samples_ff, out_samples_in;

   logic               live;
   logic [TIME_W-1:0]  gap;
   logic               start_div;
   logic               do_accept;
   logic               emit;
   logic               far;
   logic               complete;
   logic [CNT_W:0]     cnt_next;
   logic [POINT_W:0]   point_next;
   logic [CMP_W-1:0]   sx, sy, ax, ay, dx, dy, lim;

   assign live       = running_ff && (point_ff < POINT_W'(POINTS));
   assign gap        = item_ff.now_ms - last_time_ff;
   assign cnt_next   = {1'b0, cnt_ff} + 1'b1;
   assign point_next = {1'b0, point_ff} + 1'b1;

   // per-axis distance from the truncated average
   assign sx  = CMP_W'(item_ff.sample_x);
   assign sy  = CMP_W'(item_ff.sample_y);
   assign ax  = CMP_W'(div_x_rsp.quotient);
   assign ay  = CMP_W'(div_y_rsp.quotient);
   assign dx  = (sx > ax) ? sx - ax : ax - sx;
   assign dy  = (sy > ay) ? sy - ay : ay - sy;
   assign lim = CMP_W'(cfg.max_deviation);

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      running_in      = running_ff;
      point_in        = point_ff;
      prev_valid_in   = prev_valid_ff;
      last_time_in    = last_time_ff;
      sum_x_in        = sum_x_ff;
      sum_y_in        = sum_y_ff;
      cnt_in          = cnt_ff;
      out_valid_in    = out_valid_ff;
      out_complete_in = out_complete_ff;
      out_accepted_in = out_accepted_ff;
      out_far_in      = out_far_ff;
      out_active_in   = out_active_ff;
      out_point_in    = out_point_ff;
      out_samples_in  = out_samples_ff;
      q_pop           = 1'b0;
      start_div       = 1'b0;
      do_accept       = 1'b0;
      emit            = 1'b0;
      far             = 1'b0;
      complete        = 1'b0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_rd.valid && !out_valid_ff) begin
               q_pop    = 1'b1;
               item_in  = q_rd.item;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (item_ff.kind)
               KIND_START: begin
                  running_in    = 1'b1;
                  point_in      = '0;
                  prev_valid_in = 1'b0;
                  last_time_in  = '0;
                  sum_x_in      = '0;
                  sum_y_in      = '0;
                  cnt_in        = '0;
                  emit          = 1'b1;
               end
               KIND_RELEASE: begin
                  if (live) begin
                     prev_valid_in = 1'b0;
                     last_time_in  = '0;
                  end
                  emit = 1'b1;
               end
               KIND_TOUCH: begin
                  if (live) begin
                     prev_valid_in = 1'b1;
                     if (!prev_valid_ff && (gap >= TIME_W'(cfg.debounce_ms))) begin
                        if (cnt_ff != '0) begin
                           start_div = 1'b1;
                           state_in  = S_DIV;
                        end else begin
                           do_accept = 1'b1;
                           emit      = 1'b1;
                        end
                     end else begin
                        emit = 1'b1;
                     end
                  end else begin
                     emit = 1'b1;
                  end
               end
               default: begin
                  emit = 1'b1;
               end
            endcase
         end
         S_DIV: begin
            if (div_x_rsp.done && div_y_rsp.done) begin
               far       = (dx > lim) || (dy > lim);
               do_accept = !far;
               emit      = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_accept) begin
         last_time_in = item_ff.now_ms;
         if (cnt_next >= (CNT_W + 1)'(SAMPLES)) begin
            // point done: next point starts with empty sums
            point_in = point_next[POINT_W-1:0];
            cnt_in   = '0;
            sum_x_in = '0;
            sum_y_in = '0;
            if (point_next >= (POINT_W + 1)'(POINTS)) begin
               complete   = 1'b1;
               running_in = 1'b0;
            end
         end else begin
            cnt_in   = cnt_next[CNT_W-1:0];
            sum_x_in = sum_x_ff + SUM_W'(item_ff.sample_x);
            sum_y_in = sum_y_ff + SUM_W'(item_ff.sample_y);
         end
      end

      if (emit) begin
         state_in        = S_IDLE;
         out_valid_in    = 1'b1;
         out_complete_in = complete;
         out_accepted_in = do_accept;
         out_far_in      = far;
         out_active_in   = running_in;
         out_point_in    = OUT_PT_W'(point_in);
         out_samples_in  = (point_in < POINT_W'(POINTS)) ? OUT_PS_W'(cnt_in) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         running_ff    <= 1'b0;
         point_ff      <= '0;
         prev_valid_ff <= 1'b0;
         last_time_ff  <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         cnt_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         point_ff      <= point_in;
         prev_valid_ff <= prev_valid_in;
         last_time_ff  <= last_time_in;
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         cnt_ff        <= cnt_in;
         out_valid_ff  <= out_valid_in;
      end
      item_ff         <= item_in;
      out_complete_ff <= out_complete_in;
      out_accepted_ff <= out_accepted_in;
      out_far_ff      <= out_far_in;
      out_active_ff   <= out_active_in;
      out_point_ff    <= out_point_in;
      out_samples_ff  <= out_samples_in;
   end

   assign div_x_req.start    = start_div;
   assign div_x_req.dividend = sum_x_ff;
   assign div_x_req.divisor  = cnt_ff;
   assign div_y_req.start    = start_div;
   assign div_y_req.dividend = sum_y_ff;
   assign div_y_req.divisor  = cnt_ff;

   assign rsp.valid         = out_valid_ff;
   assign rsp.complete      = out_complete_ff;
   assign rsp.accepted      = out_accepted_ff;
   assign rsp.rejected_far  = out_far_ff;
   assign rsp.active        = out_active_ff;
   assign rsp.point_index   = out_point_ff;
   assign rsp.point_samples = out_samples_ff;

`ifndef SYNTHESIS
   a_far_not_taken: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_accepted_ff && out_far_ff))
      else $error("far sample reported as accepted");

   a_complete_stops: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_complete_ff) |-> (out_accepted_ff && !out_active_ff))
      else $error("completion without accept or with run still active");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !out_valid_ff)
      else $error("result pending while an item is being worked");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cnt_ff} < (CNT_W + 1)'(SAMPLES))
      else $error("sample count reached point size without advancing");

   a_running_point: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (point_ff < POINT_W'(POINTS)))
      else $error("run active past the last point");
`endif

endmodule

// ===== rtl/touch_calibration_sample_collector_unit.sv =====
// Top level of the touch calibration sample collector.
`timescale 1ns / 1ps

// Collects touch-panel samples for a calibration run over POINTS targets,
// SAMPLES accepted samples per target. A start beat clears the run and begins
// at point 0; during a run only rising edges of touch_valid count, gated by the
// debounce time and, from the second sample of a point on, by the distance of
// each axis from the truncated running average. Every request beat returns
// exactly one response beat. Flow: a beat is registered in the front stage,
// then sits in a two-entry queue; the back pops it into its item register
// and answers from its response register for starts, releases, held or
// debounced touches and the first sample of a point. A sample that needs the
// deviation check first runs the two serial dividers (x and y in parallel,
// one quotient bit per cycle, SUM_W = 14 steps). The back works one beat at
// a time and pops only once the response register is empty; the front and
// queue keep taking beats meanwhile until both are full. Configuration writes
// (debounce_ms at index 0, max_deviation at index 1) take effect on the next
// cycle and are meant to be made while no beat is in flight. No memory
// clearing is needed after reset: only the current point's sums are kept.

module touch_calibration_sample_collector_unit (
   input  logic                               clock,
   input  logic                               reset,
   tcsc_req_if.sink                           req_bus,
   tcsc_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [tcsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcsc_pkg::*;

   // configuration registers
   logic [DEB_W-1:0] debounce_ff, debounce_in;
   logic [DEV_W-1:0] max_dev_ff, max_dev_in;
   cfg_type          cfg;

   q_wr_type    q_wr;
   q_rd_type    q_rd;
   logic        q_full;
   logic        q_pop;
   div_req_type div_x_req, div_y_req;
   div_rsp_type div_x_rsp, div_y_rsp;

   always_comb begin
      debounce_in = debounce_ff;
      max_dev_in  = max_dev_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wdata[DEB_W-1:0];
            CSR_MAX_DEV:  max_dev_in  = csr_wdata[DEV_W-1:0];
            default: begin
               debounce_in = debounce_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         max_dev_ff  <= MAX_DEV_RST;
      end else begin
         debounce_ff <= debounce_in;
         max_dev_ff  <= max_dev_in;
      end
   end

   assign cfg.debounce_ms   = debounce_ff;
   assign cfg.max_deviation = max_dev_ff;

   // front: accept and classify beats
   tcsc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_full (q_full),
      .q_wr   (q_wr)
   );

   // queue decoupling front from back
   tcsc_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_rd   (q_rd)
   );

   // running-average dividers, one per axis
   tcsc_div u_div_x (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_x_req),
      .div_rsp (div_x_rsp)
   );

   tcsc_div u_div_y (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_y_req),
      .div_rsp (div_y_rsp)
   );

   // back: run state, checks, sums and response register
   tcsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_rd      (q_rd),
      .q_pop     (q_pop),
      .div_x_req (div_x_req),
      .div_y_req (div_y_req),
      .div_x_rsp (div_x_rsp),
      .div_y_rsp (div_y_rsp),
      .rsp       (rsp_bus)
   );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the touch calibration sample collector.
`timescale 1ns / 1ps

module tb_top;
   import tcsc_pkg::*;

   // ---------------------------------------------------------------------
   // Beat layouts as seen by the testbench
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic              action;
      logic [RAW_W-1:0]  x;
      logic [RAW_W-1:0]  y;
      logic              touch;
      logic [TIME_W-1:0] now;
   } sample_type;

   typedef struct packed {
      logic                complete;
      logic                accepted;
      logic                far;
      logic                active;
      logic [OUT_PT_W-1:0] pt;
      logic [OUT_PS_W-1:0] ps;
   } status_type;

   typedef struct packed {
      sample_type s;
      logic       chk;   // 1: use the hand-written status below
      status_type want;
   } dir_row_type;

   localparam logic ACT_TOUCH = 1'b0;
   localparam logic ACT_START = 1'b1;

   localparam int RAW_MAX        = (1 << RAW_W) - 1;
   localparam int IDLE_PCT       = 19;
   localparam int PHASE_ITEMS    = 210;
   localparam int DRAIN_CYCLES   = 40;    // margin for the back end's divider path
   localparam int HOLD_AT        = 150;   // response beats seen before the long hold
   localparam int HOLD_CYCLES    = 400;
   localparam int CALM_LO        = 500;   // window with no idling on either side
   localparam int CALM_HI        = 650;
   localparam int WATCHDOG_LIMIT = 3000;

   // ---------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ---------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tcsc_req_if req_bus ();
   tcsc_rsp_if rsp_bus ();

   touch_calibration_sample_collector_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Collector model: config copy and run state. Only the current point's
   // sums are kept; later points always start from zero.
   // ---------------------------------------------------------------------
   logic [DEB_W-1:0]   cfg_debounce = DEBOUNCE_RST;
   logic [DEV_W-1:0]   cfg_maxdev   = MAX_DEV_RST;
   logic               run_on       = 1'b0;
   logic [POINT_W-1:0] cur_pt       = '0;
   logic               prev_touch   = 1'b0;
   logic [TIME_W-1:0]  last_ms      = '0;
   logic [SUM_W-1:0]   acc_x        = '0;
   logic [SUM_W-1:0]   acc_y        = '0;
   logic [CNT_W-1:0]   acc_n        = '0;

   status_type status_due[$];   // expected status beats, oldest first

   int sent       = 0;       // request beats accepted
   int rsp_seen   = 0;       // response beats accepted
   int mismatches = 0;
   int stall_cycles = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   // stimulus shaping state
   bit               pressing  = 1'b0;
   logic [POINT_W-1:0] center_pt = '1;
   int               center_x  = 0;
   int               center_y  = 0;

   // One beat through the collector model; returns the status it reports.
   function automatic status_type collect_step(input sample_type s);
      status_type        r;
      logic [TIME_W-1:0] gap;
      logic              rise;
      int                avg_x;
      int                avg_y;
      int                dx;
      int                dy;
      r = '0;
      if (s.action == ACT_START) begin
         run_on     = 1'b1;
         cur_pt     = '0;
         prev_touch = 1'b0;
         last_ms    = '0;
         acc_x      = '0;
         acc_y      = '0;
         acc_n      = '0;
      end else if (run_on && cur_pt < POINTS) begin
         rise       = s.touch && !prev_touch;
         prev_touch = s.touch;
         gap        = s.now - last_ms;   // wraps mod 2^32
         if (!s.touch) begin
            last_ms = '0;
         end else if (rise && gap >= cfg_debounce) begin
            // first sample of a point skips the distance check
            if (acc_n != 0) begin
               avg_x = int'(acc_x / acc_n);
               avg_y = int'(acc_y / acc_n);
               dx = int'(s.x) - avg_x;
               dy = int'(s.y) - avg_y;
               if (dx < 0) dx = -dx;
               if (dy < 0) dy = -dy;
               if (dx > int'(cfg_maxdev) || dy > int'(cfg_maxdev)) r.far = 1'b1;
            end
            if (!r.far) begin
               last_ms    = s.now;
               acc_x      = acc_x + SUM_W'(s.x);
               acc_y      = acc_y + SUM_W'(s.y);
               acc_n      = acc_n + 1'b1;
               r.accepted = 1'b1;
               if (acc_n >= SAMPLES) begin
                  cur_pt = cur_pt + 1'b1;
                  acc_x  = '0;
                  acc_y  = '0;
                  acc_n  = '0;
                  if (cur_pt >= POINTS) begin
                     r.complete = 1'b1;
                     run_on     = 1'b0;
                  end
               end
            end
         end
      end
      r.active = run_on;
      r.pt     = cur_pt;
      r.ps     = (cur_pt < POINTS) ? acc_n : '0;
      return r;
   endfunction

   function automatic status_type st(input int c, input int a, input int f, input int act,
                                     input int pt, input int ps);
      status_type r;
      r.complete = c[0];
      r.accepted = a[0];
      r.far      = f[0];
      r.active   = act[0];
      r.pt       = pt[OUT_PT_W-1:0];
      r.ps       = ps[OUT_PS_W-1:0];
      return r;
   endfunction

   function automatic dir_row_type row(input logic action, input int x, input int y,
                                       input logic touch, input logic [TIME_W-1:0] now,
                                       input logic chk, input status_type want);
      dir_row_type r;
      r.s.action = action;
      r.s.x      = x[RAW_W-1:0];
      r.s.y      = y[RAW_W-1:0];
      r.s.touch  = touch;
      r.s.now    = now;
      r.chk      = chk;
      r.want     = want;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offer one beat, with random idle cycles ahead of it, and record what
   // the collector should answer once the beat is taken.
   task automatic offer_beat(input sample_type s, input logic chk, input status_type want);
      status_type calc;
      while (!(sent >= CALM_LO && sent < CALM_HI) && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= s.action;
      req_bus.raw_x       <= s.x;
      req_bus.raw_y       <= s.y;
      req_bus.touch_valid <= s.touch;
      req_bus.now_ms      <= s.now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      calc = collect_step(s);
      status_due.push_back(chk ? want : calc);
      sent++;
   endtask

   // Stop offering, let every expected beat come back, then give the back
   // end time to go quiet before touching the registers.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back; entered and left on a clock edge.
   task automatic load_config(input logic [DEB_W-1:0] deb, input logic [DEV_W-1:0] dev);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= CSR_MAX_DEV;
      csr_wdata <= CSR_DATA_W'(dev);
      @(posedge clock);
      csr_we       <= 1'b0;
      cfg_debounce = deb;
      cfg_maxdev   = dev;
   endtask

   // Random beat. Mostly press/release pairs clustered around a per-point
   // target so runs actually progress; some far presses, held touches,
   // early presses (debounce), noise and the odd restart.
   task automatic gen_sample(output sample_type s);
      int roll;
      int half;
      int ox;
      int oy;
      s        = '0;
      s.action = ACT_TOUCH;
      roll     = int'($urandom_range(199));
      if (roll == 0 || (!run_on && roll < 100)) begin
         s.action  = ACT_START;
         s.x       = RAW_W'($urandom);
         s.y       = RAW_W'($urandom);
         s.touch   = 1'($urandom);
         s.now     = $urandom;
         pressing  = 1'b0;
         center_pt = '1;
      end else if (roll < 12) begin
         s.x      = RAW_W'($urandom);
         s.y      = RAW_W'($urandom);
         s.touch  = 1'($urandom);
         s.now    = $urandom;
         pressing = s.touch;
      end else if (pressing) begin
         // release most of the time, otherwise a held touch
         s.x      = RAW_W'($urandom);
         s.y      = RAW_W'($urandom);
         s.touch  = ($urandom_range(99) < 15);
         s.now    = $urandom;
         pressing = s.touch;
      end else begin
         if (center_pt != cur_pt) begin
            center_x  = int'($urandom_range(RAW_MAX));
            center_y  = int'($urandom_range(RAW_MAX));
            center_pt = cur_pt;
         end
         if ($urandom_range(99) < 80) begin
            half = int'(cfg_maxdev) / 2;
            ox = center_x + int'($urandom_range(2 * half)) - half;
            oy = center_y + int'($urandom_range(2 * half)) - half;
            if (ox < 0) ox = 0;
            if (oy < 0) oy = 0;
            if (ox > RAW_MAX) ox = RAW_MAX;
            if (oy > RAW_MAX) oy = RAW_MAX;
         end else begin
            ox = int'($urandom_range(RAW_MAX));
            oy = int'($urandom_range(RAW_MAX));
         end
         s.x   = ox[RAW_W-1:0];
         s.y   = oy[RAW_W-1:0];
         s.now = ($urandom_range(99) < 85) ? $urandom
                                           : $urandom_range(int'(cfg_debounce) + 2);
         s.touch  = 1'b1;
         pressing = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, one long hold to fill the block
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!hold_done && rsp_seen >= HOLD_AT) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1'b1;
      end else if (rsp_seen >= CALM_LO && rsp_seen < CALM_HI) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic flag_mismatch(input bit orphan, input status_type want,
                                input status_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (orphan)
            $display("%0t: status beat with nothing pending: c%0d a%0d f%0d act%0d pt%0d ps%0d",
                     $realtime, got.complete, got.accepted, got.far, got.active, got.pt, got.ps);
         else
            $display({"%0t: status mismatch: want c%0d a%0d f%0d act%0d pt%0d ps%0d, ",
                      "got c%0d a%0d f%0d act%0d pt%0d ps%0d"},
                     $realtime, want.complete, want.accepted, want.far, want.active, want.pt,
                     want.ps, got.complete, got.accepted, got.far, got.active, got.pt, got.ps);
      end
   endtask

   // Checker: compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.complete = rsp_bus.complete;
         got.accepted = rsp_bus.accepted;
         got.far      = rsp_bus.rejected_far;
         got.active   = rsp_bus.active;
         got.pt       = rsp_bus.point_index;
         got.ps       = rsp_bus.point_samples;
         rsp_seen <= rsp_seen + 1;
         if (status_due.size() == 0) begin
            flag_mismatch(1'b1, '0, got);
         end else begin
            want = status_due.pop_front();
            if (got.complete !== want.complete || got.accepted !== want.accepted ||
                got.far !== want.far || got.active !== want.active ||
                got.pt !== want.pt || got.ps !== want.ps)
               flag_mismatch(1'b0, want, got);
         end
      end
   end

   // Watchdog: cycles without a beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      dir_row_type dir_rows[$];
      sample_type  s;
      int          ph;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.action      <= ACT_TOUCH;
      req_bus.raw_x       <= '0;
      req_bus.raw_y       <= '0;
      req_bus.touch_valid <= 1'b0;
      req_bus.now_ms      <= '0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_DEBOUNCE;
      csr_wdata           <= '0;

      // Directed table, reset config (debounce 100, deviation 200).
      // touch before any start: ignored, status only
      dir_rows.push_back(row(ACT_TOUCH, RAW_MAX, RAW_MAX, 1'b1, 32'hFFFF_FFFF,
                             1'b1, st(0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(row(ACT_START, 0, 0, 1'b0, 32'h0, 1'b1, st(0, 0, 0, 1, 0, 0)));
      // rising edge 99 ms after the cleared stamp: debounced, no flag
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b1, 32'd99, 1'b1, st(0, 0, 0, 1, 0, 0)));
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b0, 32'h0, 1'b0, '0));
      // exactly the debounce gap: first sample of point 0, no distance check
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b1, 32'd100, 1'b1, st(0, 1, 0, 1, 0, 1)));
      // held touch: ignored
      dir_rows.push_back(row(ACT_TOUCH, 123, 456, 1'b1, 32'hFFFF_FFFF, 1'b0, '0));
      dir_rows.push_back(row(ACT_TOUCH, RAW_MAX, RAW_MAX, 1'b0, 32'hFFFF_FFFF, 1'b0, '0));
      // far in x
      dir_rows.push_back(row(ACT_TOUCH, RAW_MAX, 0, 1'b1, 32'd1000, 1'b1, st(0, 0, 1, 1, 0, 1)));
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b0, 32'd1000, 1'b0, '0));
      // one past the limit in y
      dir_rows.push_back(row(ACT_TOUCH, 0, 201, 1'b1, 32'd1000, 1'b1, st(0, 0, 1, 1, 0, 1)));
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b0, 32'd1000, 1'b0, '0));
      // exactly at the limit on both axes
      dir_rows.push_back(row(ACT_TOUCH, 200, 200, 1'b1, 32'd2000, 1'b1, st(0, 1, 0, 1, 0, 2)));
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b0, 32'd2000, 1'b0, '0));
      // average is 100: 301 is one over
      dir_rows.push_back(row(ACT_TOUCH, 301, 100, 1'b1, 32'd3000, 1'b0, '0));
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b0, 32'd3000, 1'b0, '0));
      // third sample closes point 0
      dir_rows.push_back(row(ACT_TOUCH, 300, 1, 1'b1, 32'd3000, 1'b1, st(0, 1, 0, 1, 1, 0)));
      dir_rows.push_back(row(ACT_TOUCH, 0, 0, 1'b0, 32'd4000, 1'b0, '0));
      dir_rows.push_back(row(ACT_TOUCH, RAW_MAX, RAW_MAX, 1'b1, 32'd5000, 1'b0, '0));
      // start during a run: back to point 0, sums cleared
      dir_rows.push_back(row(ACT_START, 12'hAAA, 12'h555, 1'b1, 32'h5555_AAAA,
                             1'b1, st(0, 0, 0, 1, 0, 0)));
      dir_rows.push_back(row(ACT_TOUCH, 12'hAAA, 12'h555, 1'b1, 32'hFFFF_FFFF, 1'b0, '0));
      dir_rows.push_back(row(ACT_TOUCH, 12'h555, 12'hAAA, 1'b0, 32'hAAAA_5555, 1'b0, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) offer_beat(dir_rows[i].s, dir_rows[i].chk, dir_rows[i].want);

      // Random phases, one register setting each; extremes included.
      for (ph = 0; ph < 5; ph++) begin
         if (ph != 0) begin
            quiesce();
            case (ph)
               1: load_config('0, '0);
               2: load_config('1, '1);
               3: load_config(DEB_W'($urandom_range(300)), DEV_W'($urandom_range(400)));
               default: load_config(DEBOUNCE_RST, MAX_DEV_RST);
            endcase
         end
         repeat (PHASE_ITEMS) begin
            gen_sample(s);
            offer_beat(s, 1'b0, '0);
         end
      end

      quiesce();
      if (mismatches == 0 && status_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
